// ===== rtl/core/length_prefixed_frame_receiver_macros.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
`define LPFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LPFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPFR_ASSERT(label, prop, msg)
`define LPFR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/lpfr_pkg.sv =====
// Types and constants of the length-prefixed frame receiver.
package lpfr_pkg;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 7;

  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam int HEAD_BYTES = 2;

  typedef struct packed {
    logic              is_entry;
    logic [BYTE_W-1:0] flag_data;
    logic              frame_done;
    logic              frame_aborted;
    logic              done_buffer;
    logic              byte_dropped;
    logic [1:0]        full_mask;
  } lpfr_stat_t;

endpackage

// ===== rtl/core/lpfr_if.sv =====
// Request and response channel interfaces of the frame receiver.
interface lpfr_req_if;
  logic                        valid;
  logic                        ready;
  logic [lpfr_pkg::CMD_W-1:0]  cmd;
  logic [lpfr_pkg::BYTE_W-1:0] rx_byte;
  logic                        buffer_select;
  logic [lpfr_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, cmd, rx_byte, buffer_select, read_index, input ready);
  modport sink   (input valid, cmd, rx_byte, buffer_select, read_index, output ready);
endinterface

interface lpfr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lpfr_pkg::BYTE_W-1:0] read_data;
  logic                        frame_done;
  logic                        frame_aborted;
  logic                        done_buffer;
  logic                        byte_dropped;
  logic [1:0]                  full_mask;

  modport source (output valid, read_data, frame_done, frame_aborted, done_buffer,
                  byte_dropped, full_mask, input ready);
  modport sink   (input valid, read_data, frame_done, frame_aborted, done_buffer,
                  byte_dropped, full_mask, output ready);
endinterface

// ===== rtl/core/lpfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 130
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lpfr_ctrl.sv =====
// Frame tracking, buffer flags and frame store address generation.
`include "length_prefixed_frame_receiver_macros.svh"

module lpfr_ctrl #(
  parameter int MAX_FRAME = 65
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [lpfr_pkg::CMD_W-1:0]           cmd,
  input  logic [lpfr_pkg::BYTE_W-1:0]          rx_byte,
  input  logic                                 buffer_select,
  input  logic [lpfr_pkg::IDX_W-1:0]           read_index,
  output logic                                 mem_we,
  output logic [$clog2(2*MAX_FRAME)-1:0]       mem_waddr,
  output logic [lpfr_pkg::BYTE_W-1:0]          mem_wdata,
  output logic                                 mem_re,
  output logic [$clog2(2*MAX_FRAME)-1:0]       mem_raddr,
  output lpfr_pkg::lpfr_stat_t                 stat
);

  import lpfr_pkg::*;

  localparam int PW = $clog2(MAX_FRAME + 1);
  localparam int AW = $clog2(2 * MAX_FRAME);
  localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_FRAME - HEAD_BYTES);

  logic [BYTE_W-1:0] buffer_flags [2];
  logic [BYTE_W-1:0] buffer_flags_next [2];
  logic [PW-1:0]     byte_position;
  logic [PW-1:0]     expected_count;
  logic              target_buffer;

  logic              is_byte;
  logic              is_read;
  logic              is_release;
  logic              frame_start;
  logic [1:0]        flag_nz;
  logic              sel_buf;
  logic              take;
  logic [PW-1:0]     pos;
  logic [BYTE_W-1:0] len_clamped;
  logic [PW-1:0]     exp_eff;
  logic              all_in;
  logic              close;
  logic [BYTE_W-1:0] flag_val;
  logic              byte_commit;
  logic              idx_entry;

  assign is_byte     = (cmd == CMD_BYTE);
  assign is_read     = (cmd == CMD_READ);
  assign is_release  = (cmd == CMD_RELEASE);
  assign frame_start = (byte_position == '0);
  assign flag_nz[0]  = (buffer_flags[0] != '0);
  assign flag_nz[1]  = (buffer_flags[1] != '0);
  assign sel_buf     = frame_start ? flag_nz[0] : target_buffer;
  assign take        = !(frame_start && flag_nz[0] && flag_nz[1]);
  assign pos         = byte_position + PW'(1);
  assign len_clamped = (rx_byte > LEN_MAX) ? LEN_MAX : rx_byte;
  assign exp_eff     = (pos == PW'(HEAD_BYTES)) ? PW'(len_clamped + BYTE_W'(HEAD_BYTES))
                                                : expected_count;
  assign all_in      = (pos == exp_eff);
  assign close       = all_in || (rx_byte == '0);
  assign flag_val    = {!all_in, 7'(pos)};
  assign byte_commit = accept && is_byte && take;
  assign idx_entry   = (read_index != '0) && (read_index <= IDX_W'(MAX_FRAME));

  assign mem_we    = byte_commit;
  assign mem_waddr = AW'(byte_position) + (sel_buf ? AW'(MAX_FRAME) : AW'(0));
  assign mem_wdata = rx_byte;
  assign mem_re    = accept && is_read && idx_entry;
  assign mem_raddr = AW'(read_index - IDX_W'(1)) + (buffer_select ? AW'(MAX_FRAME) : AW'(0));

  always_comb begin
    buffer_flags_next[0] = buffer_flags[0];
    buffer_flags_next[1] = buffer_flags[1];
    if (byte_commit && close) begin
      buffer_flags_next[sel_buf] = flag_val;
    end else if (accept && is_release) begin
      buffer_flags_next[buffer_select] = '0;
    end
  end

  always_comb begin
    stat.is_entry      = is_read && idx_entry;
    stat.flag_data     = (is_read && read_index == '0) ? buffer_flags[buffer_select] : '0;
    stat.frame_done    = is_byte && take && close;
    stat.frame_aborted = is_byte && take && close && !all_in;
    stat.done_buffer   = is_byte && take && close && sel_buf;
    stat.byte_dropped  = is_byte && !take;
    stat.full_mask     = {buffer_flags_next[1] != '0, buffer_flags_next[0] != '0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_flags[0] <= '0;
      buffer_flags[1] <= '0;
      byte_position   <= '0;
      expected_count  <= PW'(MAX_FRAME);
      target_buffer   <= 1'b0;
    end else begin
      if (accept) begin
        buffer_flags[0] <= buffer_flags_next[0];
        buffer_flags[1] <= buffer_flags_next[1];
      end
      if (byte_commit) begin
        target_buffer <= sel_buf;
        if (close) begin
          byte_position  <= '0;
          expected_count <= PW'(MAX_FRAME);
        end else begin
          byte_position  <= pos;
          expected_count <= exp_eff;
        end
      end
    end
  end

  `LPFR_ASSERT(a_pos_below_expected, byte_position < expected_count, "frame position overran expected count")
  `LPFR_ASSERT(a_expected_range, (expected_count >= PW'(HEAD_BYTES)) && (expected_count <= PW'(MAX_FRAME)), "expected count out of range")
  `LPFR_ASSERT(a_target_free, (byte_position != '0) |-> (buffer_flags[target_buffer] == '0), "frame in progress on a full buffer")

endmodule

// ===== rtl/core/length_prefixed_frame_receiver.sv =====
// Stages a and o are registered. One transaction per cycle unless rsp.ready stalls
// the output; the single write port of the frame store takes one byte per cycle and its
// one read port serves one entry read per cycle.
// Reset (synchronous, active high) empties both buffer flags, clears the frame
// position and pipeline valids; the frame store itself is not cleared.
`include "length_prefixed_frame_receiver_macros.svh"

module length_prefixed_frame_receiver #(
  parameter int MAX_FRAME = 65
) (
  input logic clk,
  input logic rst,
  lpfr_req_if.sink   req,
  lpfr_rsp_if.source rsp
);

  import lpfr_pkg::*;

  localparam int AW = $clog2(2 * MAX_FRAME);

  logic              accept;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  lpfr_stat_t        stat;

  logic              a_valid;
  lpfr_stat_t        a_stat;
  logic              a_adv;

  logic              o_valid;
  logic [BYTE_W-1:0] o_read_data;
  lpfr_stat_t        o_stat;

  assign a_adv     = a_valid && (!o_valid || rsp.ready);
  assign req.ready = !a_valid || a_adv;
  assign accept    = req.valid && req.ready;

  lpfr_ctrl #(
    .MAX_FRAME(MAX_FRAME)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (req.cmd),
    .rx_byte      (req.rx_byte),
    .buffer_select(req.buffer_select),
    .read_index   (req.read_index),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .stat         (stat)
  );

  lpfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(2 * MAX_FRAME)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        a_valid <= req.valid;
      end
      if (a_adv) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_stat <= stat;
    end
    if (a_adv) begin
      o_stat      <= a_stat;
      o_read_data <= a_stat.is_entry ? mem_rdata : a_stat.flag_data;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.read_data     = o_read_data;
  assign rsp.frame_done    = o_stat.frame_done;
  assign rsp.frame_aborted = o_stat.frame_aborted;
  assign rsp.done_buffer   = o_stat.done_buffer;
  assign rsp.byte_dropped  = o_stat.byte_dropped;
  assign rsp.full_mask     = o_stat.full_mask;

  `LPFR_ASSERT(a_stage_holds, (a_valid && !a_adv) |=> a_valid, "pending transaction lost in stage")
  `LPFR_ASSERT(a_done_sets_full, (o_valid && o_stat.frame_done) |-> o_stat.full_mask[o_stat.done_buffer], "closed frame left its buffer empty")
  `LPFR_ASSERT(a_done_not_dropped, o_valid |-> !(o_stat.frame_done && o_stat.byte_dropped), "byte both dropped and closing a frame")

endmodule

// ===== tb/length_prefixed_frame_receiver_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the length-prefixed frame receiver: directed and random traffic.
module length_prefixed_frame_receiver_test;
  import lpfr_pkg::*;

  localparam int MAX_FRAME = 65;
  localparam int LEN_CAP = MAX_FRAME - HEAD_BYTES;
  localparam logic [BYTE_W-1:0] ABORT_MARK = 8'h80;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic              buffer_select;
    logic [IDX_W-1:0]  read_index;
  } req_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              frame_done;
    logic              frame_aborted;
    logic              done_buffer;
    logic              byte_dropped;
    logic [1:0]        full_mask;
  } status_item_t;

  class receiver_shadow;
    logic [BYTE_W-1:0] flags [2];
    logic [BYTE_W-1:0] store [2][1:MAX_FRAME];
    bit                written [2][1:MAX_FRAME];
    int unsigned       position;
    int unsigned       frame_len;
    bit                target;
    status_item_t      due_status [$];
    int                errors;

    function new();
      flags[0] = '0;
      flags[1] = '0;
      position = 0;
      frame_len = MAX_FRAME;
      target = 1'b0;
      errors = 0;
    endfunction

    function bit both_full();
      return flags[0] != 0 && flags[1] != 0;
    endfunction

    function int pending();
      return due_status.size();
    endfunction

    function void apply_request(req_item_t it);
      status_item_t st;
      int unsigned  p;
      int unsigned  len;
      bit           take;
      bit           closes;
      st = '0;
      case (it.cmd)
        CMD_BYTE: begin
          take = 1'b1;
          if (position == 0) begin
            if (flags[0] == 0) target = 1'b0;
            else if (flags[1] == 0) target = 1'b1;
            else take = 1'b0;
          end
          if (!take) begin
            st.byte_dropped = 1'b1;
          end else begin
            p = position + 1;
            store[target][p] = it.rx_byte;
            written[target][p] = 1'b1;
            if (p == HEAD_BYTES) begin
              len = it.rx_byte;
              if (len > LEN_CAP) len = LEN_CAP;
              frame_len = len + HEAD_BYTES;
            end
            closes = (p == frame_len) || (it.rx_byte == 0);
            if (closes) begin
              flags[target] = BYTE_W'(p) | ((p != frame_len) ? ABORT_MARK : '0);
              st.frame_done = 1'b1;
              st.frame_aborted = (p != frame_len);
              st.done_buffer = target;
              position = 0;
              frame_len = MAX_FRAME;
            end else begin
              position = p;
            end
          end
        end
        CMD_READ: begin
          if (it.read_index == 0) st.read_data = flags[it.buffer_select];
          else if (it.read_index <= MAX_FRAME)
            st.read_data = store[it.buffer_select][it.read_index];
        end
        CMD_RELEASE: flags[it.buffer_select] = '0;
        default: ;
      endcase
      st.full_mask = {flags[1] != 0, flags[0] != 0};
      due_status.push_back(st);
    endfunction

    function void match(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      end
    endfunction

    function void check_status(status_item_t got);
      status_item_t want;
      if (due_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none got %h", $time, got);
        return;
      end
      want = due_status.pop_front();
      match("read_data", want.read_data, got.read_data);
      match("frame_done", want.frame_done, got.frame_done);
      match("frame_aborted", want.frame_aborted, got.frame_aborted);
      match("done_buffer", want.done_buffer, got.done_buffer);
      match("byte_dropped", want.byte_dropped, got.byte_dropped);
      match("full_mask", want.full_mask, got.full_mask);
    endfunction
  endclass

  logic clk;
  logic rst;
  lpfr_req_if req_ch();
  lpfr_rsp_if rsp_ch();
  receiver_shadow shadow;
  int sent;
  int burst_left;

  length_prefixed_frame_receiver #(.MAX_FRAME(MAX_FRAME)) i_dut (
    .clk,
    .rst,
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin : status_mon
    status_item_t got;
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.read_data = rsp_ch.read_data;
      got.frame_done = rsp_ch.frame_done;
      got.frame_aborted = rsp_ch.frame_aborted;
      got.done_buffer = rsp_ch.done_buffer;
      got.byte_dropped = rsp_ch.byte_dropped;
      got.full_mask = rsp_ch.full_mask;
      shadow.check_status(got);
    end
  end

  // response side: stall patterns, one long hold-off
  initial begin : status_side
    int seg;
    int run;
    int mode;
    int k;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    seg = 0;
    forever begin
      seg++;
      if (seg == 12) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(4, 40);
        for (k = 0; k < run; k++) begin
          @(negedge clk);
          case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= (k % 4 != 3);
            default: rsp_ch.ready <= (k % 3 == 0);
          endcase
        end
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] rx, logic sel,
                           logic [IDX_W-1:0] idx);
    req_item_t it;
    int gap;
    it = '{cmd: cmd, rx_byte: rx, buffer_select: sel, read_index: idx};
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.cmd <= it.cmd;
    req_ch.rx_byte <= it.rx_byte;
    req_ch.buffer_select <= it.buffer_select;
    req_ch.read_index <= it.read_index;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    shadow.apply_request(it);
    burst_left--;
    sent++;
  endtask

  task automatic rx_xact(logic [BYTE_W-1:0] b);
    send_item(CMD_BYTE, b, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 127)));
  endtask

  task automatic read_xact(logic sel, int idx);
    send_item(CMD_READ, BYTE_W'($urandom), sel, IDX_W'(idx));
  endtask

  task automatic release_xact(logic sel);
    send_item(CMD_RELEASE, BYTE_W'($urandom), sel, IDX_W'($urandom_range(0, 127)));
  endtask

  task automatic idle_xact();
    send_item(CMD_UNUSED, BYTE_W'($urandom), 1'($urandom_range(0, 1)),
              IDX_W'($urandom_range(0, 127)));
  endtask

  // flag, out of range, or an entry already written
  function automatic int pick_index(logic sel);
    int roll;
    int start;
    int k;
    int n;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 0;
    if (roll == 3) return $urandom_range(MAX_FRAME + 1, 127);
    start = $urandom_range(1, MAX_FRAME);
    for (k = 0; k < MAX_FRAME; k++) begin
      n = (start + k - 1) % MAX_FRAME + 1;
      if (shadow.written[sel][n]) return n;
    end
    return 0;
  endfunction

  task automatic frame_xact(int length_field);
    int body;
    int k;
    if (shadow.both_full() && $urandom_range(0, 9) < 7) release_xact(1'($urandom_range(0, 1)));
    rx_xact(($urandom_range(0, 19) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 255)));
    rx_xact(BYTE_W'(length_field));
    body = (length_field > LEN_CAP) ? LEN_CAP : length_field;
    if ($urandom_range(0, 9) == 0) body = $urandom_range(0, body);
    for (k = 0; k < body; k++)
      rx_xact(($urandom_range(0, 24) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 255)));
  endtask

  initial begin : stimulus
    int roll;
    int n;
    logic sel;
    bit long_done;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_BYTE;
    req_ch.rx_byte = '0;
    req_ch.buffer_select = 1'b0;
    req_ch.read_index = '0;
    shadow = new();
    sent = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    read_xact(1'b0, 0);
    read_xact(1'b1, 0);
    rx_xact(8'h00);                   // zero address aborts at once
    rx_xact(8'hFF);
    rx_xact(8'h00);                   // zero length closes at two bytes
    rx_xact(8'h55);                   // both buffers full
    read_xact(1'b0, 0);
    read_xact(1'b0, 1);
    read_xact(1'b1, 2);
    read_xact(1'b1, MAX_FRAME + 1);
    read_xact(1'b0, 127);
    release_xact(1'b0);
    idle_xact();
    rx_xact(8'h7F);
    rx_xact(8'h02);
    rx_xact(8'hAA);
    rx_xact(8'h00);                   // zero as last body byte still completes
    release_xact(1'b1);
    rx_xact(8'h10);
    release_xact(1'b1);               // release while frame in progress
    rx_xact(8'h01);
    rx_xact(8'h80);

    long_done = 1'b0;
    while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (!long_done) begin
        frame_xact($urandom_range(LEN_CAP + 1, 255));
        long_done = 1'b1;
      end else if (roll < 50) begin
        if (roll < 2) frame_xact($urandom_range(9, 40));
        else if (roll == 2) frame_xact($urandom_range(LEN_CAP - 1, 255));
        else frame_xact($urandom_range(0, 8));
      end else if (roll < 75) begin
        sel = 1'($urandom_range(0, 1));
        n = $urandom_range(1, 6);
        repeat (n) read_xact(sel, pick_index(sel));
      end else if (roll < 85) begin
        release_xact(1'($urandom_range(0, 1)));
      end else if (roll < 90) begin
        idle_xact();
      end else begin
        rx_xact(BYTE_W'($urandom));
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_if.sv
rtl/core/lpfr_ram.sv
rtl/core/lpfr_ctrl.sv
rtl/core/length_prefixed_frame_receiver.sv
tb/length_prefixed_frame_receiver_test.sv
